### rtl/core/lass_pkg.sv
// Shared constants, codes and types of the line assembler with substring search.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package lass_pkg;

  localparam int LINE_CHARS    = 32;
  localparam int STORE_LINES   = 16;
  localparam int PATTERN_MAX   = 16;

  localparam int HELD_CHARS    = LINE_CHARS - 1;
  localparam int PAT_REG_CHARS = 16;
  localparam int PAT_CAP       = (PATTERN_MAX < PAT_REG_CHARS) ? PATTERN_MAX : PAT_REG_CHARS;

  localparam int CHAR_W        = $clog2(HELD_CHARS + 1);
  localparam int PL_AW         = $clog2(HELD_CHARS);
  localparam int CNT_W         = $clog2(STORE_LINES + 1);
  localparam int SLOT_W        = (STORE_LINES > 1) ? $clog2(STORE_LINES) : 1;
  localparam int PAT_W         = $clog2(PAT_CAP + 1);
  localparam int SUM_W         = ((CHAR_W > PAT_W) ? CHAR_W : PAT_W) + 1;
  localparam int PI_W          = $clog2(PAT_REG_CHARS);
  localparam int STORE_DEPTH   = STORE_LINES * HELD_CHARS;
  localparam int ST_AW         = $clog2(STORE_DEPTH);

  localparam int CFG_W         = 64;
  localparam int CFG_IDX_W     = 2;
  localparam int PAT_LEN_W     = 5;
  localparam int SLOT_OUT_W    = 4;

  localparam logic [7:0] IGNORE_BYTE = 8'hFF;
  localparam logic [7:0] CR_BYTE     = 8'h0D;
  localparam logic [7:0] LF_BYTE     = 8'h0A;
  localparam logic [7:0] NUL_BYTE    = 8'h00;

  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LO  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_HI  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN = 2'd2;

  typedef enum logic [1:0] {
    OP_RX     = 2'd0,
    OP_SEARCH = 2'd1,
    OP_CLEAR  = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CP_RD,
    S_CP_WR,
    S_LINE,
    S_RD,
    S_CMP
  } state_t;

endpackage

`default_nettype wire

### rtl/core/lass_if.sv
// Valid/ready channel interfaces for the input items and the result items.
// Depends on lass_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface lass_in_if import lass_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

interface lass_out_if import lass_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  line_done;
  logic [SLOT_OUT_W-1:0] line_slot;
  logic                  store_overflow;
  logic                  pattern_found;

  modport source (output valid, output line_done, output line_slot,
                  output store_overflow, output pattern_found, input ready);
  modport sink   (input valid, input line_done, input line_slot,
                  input store_overflow, input pattern_found, output ready);
endinterface

`default_nettype wire

### rtl/core/line_assembler_substring_search_unit.sv
// Line assembler with substring search: top level, sequencer and memories.
// Depends on lass_pkg and the channel interfaces in lass_if.sv.
// Ignored, ordinary, clear and unused-opcode transactions stay in the idle state and
// can be accepted every cycle while the output register is free; a line end copies
// each held byte by a read and a write step (S_CP_RD, S_CP_WR); a search walks the
// slots (S_LINE) and compares bytes (S_RD, S_CMP). One transaction at a time; ready
// only while idle with the output register free. Synchronous active-low reset empties
// the line and the store and zeroes the pattern registers; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module line_assembler_substring_search_unit
  import lass_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  lass_in_if.sink                   in_ch,
  lass_out_if.source                out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  // Configuration registers
  logic [CFG_W-1:0]     pat_lo_r;
  logic [CFG_W-1:0]     pat_hi_r;
  logic [PAT_LEN_W-1:0] pat_len_r;

  // Sequencer state
  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CHAR_W-1:0]    plen_r, plen_nxt;
  logic [CHAR_W-1:0]    k_r, k_nxt;
  logic [CHAR_W-1:0]    s_r, s_nxt;
  logic [CHAR_W-1:0]    n_r, n_nxt;
  logic [CNT_W-1:0]     i_r, i_nxt;
  logic [PAT_W-1:0]     m_r, m_nxt;
  logic                 zseen_r, zseen_nxt;
  logic [CHAR_W-1:0]    zlen_r, zlen_nxt;

  // Output register
  logic                  out_valid_r, out_valid_nxt;
  logic                  done_r, done_nxt;
  logic [SLOT_OUT_W-1:0] slot_r, slot_nxt;
  logic                  ovf_r, ovf_nxt;
  logic                  found_r, found_nxt;

  // Memories
  logic [7:0]        pl_mem [HELD_CHARS];
  logic [7:0]        pl_rdata_r;
  logic              pl_we;
  logic [7:0]        st_mem [STORE_DEPTH];
  logic [7:0]        st_rdata_r;
  logic              st_we;
  logic [ST_AW-1:0]  st_waddr;
  logic [ST_AW-1:0]  st_raddr;
  logic [CHAR_W-1:0] len_mem_r [STORE_LINES];
  logic              len_we;
  logic [CHAR_W-1:0] len_wdata;

  // Pattern view
  logic [2*CFG_W-1:0] pat_word;
  logic [7:0]         pat_bytes [PAT_REG_CHARS];
  logic [PAT_W-1:0]   m_cap;
  logic [PAT_W-1:0]   m_eff;

  logic              in_fire;
  logic [CHAR_W-1:0] n_slot;

  assign in_ch.ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign out_ch.valid          = out_valid_r;
  assign out_ch.line_done      = done_r;
  assign out_ch.line_slot      = slot_r;
  assign out_ch.store_overflow = ovf_r;
  assign out_ch.pattern_found  = found_r;

  assign pat_word = {pat_hi_r, pat_lo_r};

  // Saturate the length, then cut the pattern at its first zero byte.
  always_comb begin
    for (int j = 0; j < PAT_REG_CHARS; j++) begin
      pat_bytes[j] = pat_word[j*8 +: 8];
    end
    m_cap = (pat_len_r > PAT_LEN_W'(PAT_CAP)) ? PAT_W'(PAT_CAP) : PAT_W'(pat_len_r);
    m_eff = m_cap;
    for (int j = PAT_CAP - 1; j >= 0; j--) begin
      if ((PAT_W'(j) < m_cap) && (pat_bytes[j] == NUL_BYTE)) begin
        m_eff = PAT_W'(j);
      end
    end
  end

  // Byte addresses into the line store: row of a slot plus offset in the line.
  assign st_waddr = ST_AW'(count_r[SLOT_W-1:0]) * ST_AW'(HELD_CHARS) + ST_AW'(k_r);
  assign st_raddr = ST_AW'(i_r[SLOT_W-1:0]) * ST_AW'(HELD_CHARS) + ST_AW'(s_r)
                    + ST_AW'(k_r);
  assign n_slot   = len_mem_r[i_r[SLOT_W-1:0]];

  // Next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    plen_nxt      = plen_r;
    k_nxt         = k_r;
    s_nxt         = s_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    m_nxt         = m_r;
    zseen_nxt     = zseen_r;
    zlen_nxt      = zlen_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    done_nxt      = done_r;
    slot_nxt      = slot_r;
    ovf_nxt       = ovf_r;
    found_nxt     = found_r;
    pl_we         = 1'b0;
    st_we         = 1'b0;
    len_we        = 1'b0;
    len_wdata     = plen_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          // Default result: every field zero; long transactions override below.
          out_valid_nxt = 1'b1;
          done_nxt      = 1'b0;
          slot_nxt      = '0;
          ovf_nxt       = 1'b0;
          found_nxt     = 1'b0;
          case (in_ch.opcode)
            OP_RX: begin
              if (in_ch.rx_byte == IGNORE_BYTE) begin
                // drop the byte
              end else if (in_ch.rx_byte != CR_BYTE && in_ch.rx_byte != LF_BYTE) begin
                if (plen_r < CHAR_W'(HELD_CHARS)) begin
                  pl_we    = 1'b1;
                  plen_nxt = plen_r + 1'b1;
                end
              end else if (plen_r != '0) begin
                if (count_r < CNT_W'(STORE_LINES)) begin
                  // start the copy into the next slot; result comes at its end
                  out_valid_nxt = 1'b0;
                  k_nxt         = '0;
                  zseen_nxt     = 1'b0;
                  state_nxt     = S_CP_RD;
                end else begin
                  ovf_nxt  = 1'b1;
                  plen_nxt = '0;
                end
              end
            end
            OP_SEARCH: begin
              out_valid_nxt = 1'b0;
              m_nxt         = m_eff;
              i_nxt         = '0;
              state_nxt     = S_LINE;
            end
            OP_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
              // unused opcode: zero result
            end
          endcase
        end
      end

      S_CP_RD: begin
        // partial line byte k is read this cycle
        state_nxt = S_CP_WR;
      end

      S_CP_WR: begin
        st_we = 1'b1;
        if (!zseen_r && pl_rdata_r == NUL_BYTE) begin
          zseen_nxt = 1'b1;
          zlen_nxt  = k_r;
        end
        if (({1'b0, k_r} + 1'b1) == {1'b0, plen_r}) begin
          len_we        = 1'b1;
          len_wdata     = zseen_nxt ? zlen_nxt : plen_r;
          out_valid_nxt = 1'b1;
          done_nxt      = 1'b1;
          slot_nxt      = SLOT_OUT_W'(count_r);
          ovf_nxt       = 1'b0;
          found_nxt     = 1'b0;
          count_nxt     = count_r + 1'b1;
          plen_nxt      = '0;
          state_nxt     = S_IDLE;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_CP_RD;
        end
      end

      S_LINE: begin
        if (i_r >= count_r) begin
          out_valid_nxt = 1'b1;
          done_nxt      = 1'b0;
          slot_nxt      = '0;
          ovf_nxt       = 1'b0;
          found_nxt     = 1'b0;
          state_nxt     = S_IDLE;
        end else if (SUM_W'(m_r) > SUM_W'(n_slot)) begin
          // pattern longer than the line: skip it
          i_nxt = i_r + 1'b1;
        end else begin
          n_nxt     = n_slot;
          s_nxt     = '0;
          k_nxt     = '0;
          state_nxt = S_RD;
        end
      end

      S_RD: begin
        if (SUM_W'(k_r) == SUM_W'(m_r)) begin
          out_valid_nxt = 1'b1;
          done_nxt      = 1'b0;
          slot_nxt      = '0;
          ovf_nxt       = 1'b0;
          found_nxt     = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_CMP;
        end
      end

      S_CMP: begin
        if (st_rdata_r == pat_bytes[PI_W'(k_r)]) begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_RD;
        end else if ((SUM_W'(s_r) + SUM_W'(1) + SUM_W'(m_r)) > SUM_W'(n_r)) begin
          // no start position left in this line: advance to the next slot
          i_nxt     = i_r + 1'b1;
          state_nxt = S_LINE;
        end else begin
          s_nxt     = s_r + 1'b1;
          k_nxt     = '0;
          state_nxt = S_RD;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      plen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      plen_r      <= plen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r     <= k_nxt;
    s_r     <= s_nxt;
    n_r     <= n_nxt;
    i_r     <= i_nxt;
    m_r     <= m_nxt;
    zseen_r <= zseen_nxt;
    zlen_r  <= zlen_nxt;
    done_r  <= done_nxt;
    slot_r  <= slot_nxt;
    ovf_r   <= ovf_nxt;
    found_r <= found_nxt;
  end

  // Configuration writes; an index past the list is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r  <= '0;
      pat_hi_r  <= '0;
      pat_len_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PAT_LO:  pat_lo_r  <= cfg_wdata;
        CFG_PAT_HI:  pat_hi_r  <= cfg_wdata;
        CFG_PAT_LEN: pat_len_r <= cfg_wdata[PAT_LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Partial line buffer: write at the fill level, read at the copy index
  always_ff @(posedge clk) begin
    if (pl_we) begin
      pl_mem[plen_r[PL_AW-1:0]] <= in_ch.rx_byte;
    end
    pl_rdata_r <= pl_mem[k_r[PL_AW-1:0]];
  end

  // Line store: one byte written per copy step, one byte read per compare
  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[st_waddr] <= pl_rdata_r;
    end
    st_rdata_r <= st_mem[st_raddr];
  end

  // Searchable length of each stored line
  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem_r[count_r[SLOT_W-1:0]] <= len_wdata;
    end
  end

endmodule

`default_nettype wire
